[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define TLC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlc assertion failed");

// The expression must never be true outside reset.
`define TLC_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tlc forbidden condition seen");

`endif

[design/tlc_pkg.sv]
package tlc_pkg;

  localparam int ADDR_W = 32;

  localparam int L1_SETS        = 64;
  localparam int L1_WAYS        = 4;
  localparam int L1_BLOCK_BYTES = 32;
  localparam int L2_SETS        = 512;
  localparam int L2_WAYS        = 8;
  localparam int L2_BLOCK_BYTES = 64;

  localparam int L1_OFF_W = $clog2(L1_BLOCK_BYTES);
  localparam int L1_SET_W = $clog2(L1_SETS);
  localparam int L1_TAG_W = ADDR_W - L1_OFF_W - L1_SET_W;
  localparam int L1_WAY_W = $clog2(L1_WAYS);
  localparam int L2_OFF_W = $clog2(L2_BLOCK_BYTES);
  localparam int L2_SET_W = $clog2(L2_SETS);
  localparam int L2_TAG_W = ADDR_W - L2_OFF_W - L2_SET_W;
  localparam int L2_WAY_W = $clog2(L2_WAYS);

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_RHIT  = 3'd1;
  localparam logic [2:0] ST_RMISS = 3'd2;
  localparam logic [2:0] ST_WHIT  = 3'd3;
  localparam logic [2:0] ST_WMISS = 3'd4;

  typedef struct packed {
    logic                is_write;
    logic [L1_SET_W-1:0] l1_set;
    logic [L1_TAG_W-1:0] l1_tag;
    logic [L2_SET_W-1:0] l2_set;
    logic [L2_TAG_W-1:0] l2_tag;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [L1_TAG_W-1:0] tag;
  } l1_way_t;

  typedef struct packed {
    logic [L1_WAY_W-1:0]         ptr;
    l1_way_t [L1_WAYS-1:0]       way;
  } l1_row_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [L2_TAG_W-1:0] tag;
  } l2_way_t;

  typedef struct packed {
    logic [L2_WAY_W-1:0]         ptr;
    l2_way_t [L2_WAYS-1:0]       way;
  } l2_row_t;

endpackage

[design/tlc_ram.sv]
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/tlc_front.sv]
module tlc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [tlc_pkg::ADDR_W-1:0]    in_address,
  input  logic                          clearing,
  output logic                          q_valid,
  input  logic                          q_ready,
  output tlc_pkg::item_t                q_item
);
  import tlc_pkg::*;

  item_t       q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       item_in;
  logic        push, pop;

  always_comb begin
    item_in.is_write = in_opcode;
    item_in.l1_set   = in_address[L1_OFF_W +: L1_SET_W];
    item_in.l1_tag   = in_address[ADDR_W-1 -: L1_TAG_W];
    item_in.l2_set   = in_address[L2_OFF_W +: L2_SET_W];
    item_in.l2_tag   = in_address[ADDR_W-1 -: L2_TAG_W];
  end

  assign in_ready = !clearing && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

[design/tlc_back.sv]
module tlc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  tlc_pkg::item_t q_item,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_l1_status,
  output logic [2:0]     out_l2_status
);
  import tlc_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_L1   = 6'b000100,
    S_WB   = 6'b001000,
    S_L2RD = 6'b010000,
    S_L2   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    L2_PUT = 2'd0,
    L2_RD  = 2'd1,
    L2_WR  = 2'd2
  } l2_op_t;

  state_t              state_r, state_nxt;
  logic [L2_SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t               item_r, item_nxt;
  logic [2:0]          s1_r, s1_nxt;
  logic [L2_SET_W-1:0] wb_set_r, wb_set_nxt;
  logic [L2_TAG_W-1:0] wb_tag_r, wb_tag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          l1_st_r, l1_st_nxt;
  logic [2:0]          l2_st_r, l2_st_nxt;

  logic                l1_we, l1_re;
  logic [L1_SET_W-1:0] l1_waddr, l1_raddr;
  l1_row_t             l1_wdata, l1_rdata;
  logic                l2_we, l2_re;
  logic [L2_SET_W-1:0] l2_waddr, l2_raddr;
  l2_row_t             l2_wdata, l2_rdata;

  logic                l1_hit, l1_found;
  logic [L1_WAY_W-1:0] l1_hit_way, l1_vic;
  l1_row_t             l1_new;
  logic [ADDR_W-1:0]   wb_addr;
  logic                take_wb;

  l2_op_t              l2_op;
  logic [L2_TAG_W-1:0] l2_tag;
  logic                l2_hit, l2_found;
  logic [L2_WAY_W-1:0] l2_hit_way, l2_vic;
  l2_row_t             l2_new;
  logic                l2_upd;
  logic [2:0]          l2_st;
  logic                out_free;

  tlc_ram #(.WIDTH($bits(l1_row_t)), .DEPTH(L1_SETS)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  tlc_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(L2_SETS)) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (l2_waddr),
    .wdata (l2_wdata),
    .re    (l2_re),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  // L1 lookup and allocation on the row read for the current beat.
  always_comb begin
    l1_hit     = 1'b0;
    l1_hit_way = '0;
    l1_found   = 1'b0;
    l1_vic     = l1_rdata.ptr;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (l1_rdata.way[w].valid && l1_rdata.way[w].tag == item_r.l1_tag) begin
        l1_hit     = 1'b1;
        l1_hit_way = L1_WAY_W'(w);
      end
    end
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (!l1_rdata.way[w].valid) begin
        l1_found = 1'b1;
        l1_vic   = L1_WAY_W'(w);
      end
    end
    l1_new = l1_rdata;
    if (item_r.is_write) begin
      l1_new.way[l1_hit_way].dirty = 1'b1;
    end else begin
      if (!l1_found) begin
        l1_new.ptr = l1_rdata.ptr + 1'b1;
      end
      l1_new.way[l1_vic].valid = 1'b1;
      l1_new.way[l1_vic].dirty = 1'b0;
      l1_new.way[l1_vic].tag   = item_r.l1_tag;
    end
    take_wb = l1_rdata.way[l1_vic].valid && l1_rdata.way[l1_vic].dirty;
    wb_addr = {l1_rdata.way[l1_vic].tag, item_r.l1_set, L1_OFF_W'(0)};
  end

  // L2 lookup, update and status for the row read for the current beat.
  always_comb begin
    l2_op      = (state_r == S_WB) ? L2_PUT : (item_r.is_write ? L2_WR : L2_RD);
    l2_tag     = (state_r == S_WB) ? wb_tag_r : item_r.l2_tag;
    l2_hit     = 1'b0;
    l2_hit_way = '0;
    l2_found   = 1'b0;
    l2_vic     = l2_rdata.ptr;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (l2_rdata.way[w].valid && l2_rdata.way[w].tag == l2_tag) begin
        l2_hit     = 1'b1;
        l2_hit_way = L2_WAY_W'(w);
      end
    end
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (!l2_rdata.way[w].valid) begin
        l2_found = 1'b1;
        l2_vic   = L2_WAY_W'(w);
      end
    end
    l2_new = l2_rdata;
    l2_upd = 1'b0;
    l2_st  = ST_NONE;
    if (l2_hit) begin
      if (l2_op != L2_RD) begin
        l2_new.way[l2_hit_way].dirty = 1'b1;
        l2_upd = 1'b1;
      end
      l2_st = (l2_op == L2_WR) ? ST_WHIT : ST_RHIT;
    end else if (l2_op == L2_WR) begin
      l2_st = ST_WMISS;
    end else begin
      if (!l2_found) begin
        l2_new.ptr = l2_rdata.ptr + 1'b1;
      end
      l2_new.way[l2_vic].valid = 1'b1;
      l2_new.way[l2_vic].dirty = (l2_op == L2_PUT);
      l2_new.way[l2_vic].tag   = l2_tag;
      l2_upd = 1'b1;
      l2_st  = ST_RMISS;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    s1_nxt        = s1_r;
    wb_set_nxt    = wb_set_r;
    wb_tag_nxt    = wb_tag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    l1_st_nxt     = l1_st_r;
    l2_st_nxt     = l2_st_r;
    q_ready       = 1'b0;
    l1_re         = 1'b0;
    l1_raddr      = q_item.l1_set;
    l1_we         = 1'b0;
    l1_waddr      = item_r.l1_set;
    l1_wdata      = l1_new;
    l2_re         = 1'b0;
    l2_raddr      = item_r.l2_set;
    l2_we         = 1'b0;
    l2_waddr      = (state_r == S_WB) ? wb_set_r : item_r.l2_set;
    l2_wdata      = l2_new;
    unique case (state_r)
      S_CLR: begin
        l1_we    = (clr_cnt_r[L2_SET_W-1:L1_SET_W] == '0);
        l1_waddr = clr_cnt_r[L1_SET_W-1:0];
        l1_wdata = '0;
        l2_we    = 1'b1;
        l2_waddr = clr_cnt_r;
        l2_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == L2_SET_W'(L2_SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          item_nxt  = q_item;
          l1_re     = 1'b1;
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        if (l1_hit) begin
          if (out_free) begin
            l1_we         = item_r.is_write;
            out_valid_nxt = 1'b1;
            l1_st_nxt     = item_r.is_write ? ST_WHIT : ST_RHIT;
            l2_st_nxt     = ST_NONE;
            state_nxt     = S_IDLE;
          end
        end else if (item_r.is_write) begin
          s1_nxt    = ST_WMISS;
          l2_re     = 1'b1;
          state_nxt = S_L2;
        end else begin
          s1_nxt     = ST_RMISS;
          l1_we      = 1'b1;
          l2_re      = 1'b1;
          wb_set_nxt = wb_addr[L2_OFF_W +: L2_SET_W];
          wb_tag_nxt = wb_addr[ADDR_W-1 -: L2_TAG_W];
          if (take_wb) begin
            l2_raddr  = wb_addr[L2_OFF_W +: L2_SET_W];
            state_nxt = S_WB;
          end else begin
            state_nxt = S_L2;
          end
        end
      end
      S_WB: begin
        l2_we     = l2_upd;
        state_nxt = S_L2RD;
      end
      S_L2RD: begin
        l2_re     = 1'b1;
        state_nxt = S_L2;
      end
      S_L2: begin
        if (out_free) begin
          l2_we         = l2_upd;
          out_valid_nxt = 1'b1;
          l1_st_nxt     = s1_r;
          l2_st_nxt     = l2_st;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    s1_r     <= s1_nxt;
    wb_set_r <= wb_set_nxt;
    wb_tag_r <= wb_tag_nxt;
    l1_st_r  <= l1_st_nxt;
    l2_st_r  <= l2_st_nxt;
  end

  assign clearing      = (state_r == S_CLR);
  assign out_valid     = out_valid_r;
  assign out_l1_status = l1_st_r;
  assign out_l2_status = l2_st_r;

endmodule

[design/two_level_cache_hit_miss_tracker.sv]
// Flow: an L1 hit is answered from the L1 lookup state; an L1 miss also passes
// through the L2 lookup, after a dirty L1 victim is written back into L2.
// The back end takes a new beat only once it is back in idle, after the tag
// read-modify-write in L1 and L2; the front queue takes beats meanwhile.
// Reset: synchronous, active low; afterwards a pass over all L2 sets clears both tag
// memories, and no beat is accepted until it ends.
module two_level_cache_hit_miss_tracker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [tlc_pkg::ADDR_W-1:0] in_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_l1_status,
  output logic [2:0]                 out_l2_status
);
  import tlc_pkg::*;

  logic  q_valid, q_ready, clearing;
  item_t q_item;

  tlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_address (in_address),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  tlc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_l1_status (out_l1_status),
    .out_l2_status (out_l2_status)
  );

endmodule

[design/tlc_checker.sv]
`include "assert_macros.svh"

module tlc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_opcode,
  input logic [tlc_pkg::ADDR_W-1:0] in_address,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 out_l1_status,
  input logic [2:0]                 out_l2_status
);
  import tlc_pkg::*;

  `TLC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_l1_status) && $stable(out_l2_status))
  `TLC_NEVER(a_l1_none, clk, rst_n, out_valid && out_l1_status == ST_NONE)
  `TLC_ASSERT(a_hit_no_l2, clk, rst_n, out_valid && (out_l1_status == ST_RHIT || out_l1_status == ST_WHIT) |-> out_l2_status == ST_NONE)
  `TLC_ASSERT(a_rmiss_l2, clk, rst_n, out_valid && out_l1_status == ST_RMISS |-> out_l2_status == ST_RHIT || out_l2_status == ST_RMISS)
  `TLC_ASSERT(a_wmiss_l2, clk, rst_n, out_valid && out_l1_status == ST_WMISS |-> out_l2_status == ST_WHIT || out_l2_status == ST_WMISS)

endmodule

bind two_level_cache_hit_miss_tracker tlc_checker u_tlc_checker (.*);
